FILE: src/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg: beep pattern player shared types and constants
// Transaction payloads, action and mode codes, and the fixed pattern tables.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_PLAY  = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SINGLE  = 2'd1,
        MODE_DOUBLE  = 2'd2,
        MODE_WARNING = 2'd3
    } mode_t;

    typedef struct packed {
        action_t     action;
        mode_t       pattern_mode;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic ok;
        logic pin_write;
        logic pin_high;
    } out_item_t;

    // All step limits fit in this many bits (largest is 3000 ms)
    localparam int LIMIT_W = 12;

    localparam int SINGLE_N  = 2;
    localparam int DOUBLE_N  = 4;
    localparam int WARNING_N = 12;

    // Step end times (inclusive), ascending
    localparam logic [LIMIT_W-1:0] SINGLE_LIMIT [SINGLE_N] = '{
        12'd1000, 12'd2000
    };
    localparam logic [LIMIT_W-1:0] DOUBLE_LIMIT [DOUBLE_N] = '{
        12'd750, 12'd1500, 12'd2250, 12'd3000
    };
    localparam logic [LIMIT_W-1:0] WARNING_LIMIT [WARNING_N] = '{
        12'd100,  12'd200,  12'd300,  12'd400,  12'd500,  12'd1500,
        12'd1600, 12'd1700, 12'd1800, 12'd1900, 12'd2000, 12'd2100
    };

    // Buzzer level per step, bit i for step i
    localparam logic [SINGLE_N-1:0]  SINGLE_LEVEL  = 2'b01;
    localparam logic [DOUBLE_N-1:0]  DOUBLE_LEVEL  = 4'b0101;
    localparam logic [WARNING_N-1:0] WARNING_LEVEL = 12'b0101_0101_0101;

endpackage

`default_nettype wire

FILE: src/beep_pattern_player.sv
// ----------------------------------------------------------------------------
// beep_pattern_player
// Plays fixed buzzer patterns against a free-running millisecond counter.
// ----------------------------------------------------------------------------
// Each input transaction yields exactly one result transaction. A start
// transaction stores the mode and, for a beeping mode, latches the start time
// and arms the player. A play transaction, when armed with a beeping mode,
// computes the elapsed time modulo 2^TIME_WIDTH and returns the buzzer level
// of the current pattern step; past the last step it drives the pin low and
// disarms. The block is a two-stage pipeline (input register, result register)
// and accepts one transaction per clock while the result register is free or
// m_ready is high; m_valid rises once the transaction moves into the result
// register, and throughput is limited only by m_ready. The elapsed-time
// subtract and the step compares sit in one stage between the two registers.
`default_nettype none

module beep_pattern_player #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bpp_pkg::in_item_t  s_data,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output bpp_pkg::out_item_t      m_data
);

    localparam int NOW_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int HI_W  = TIME_WIDTH - bpp_pkg::LIMIT_W;

    // Input stage
    logic               in_valid_reg, in_valid_next;
    bpp_pkg::in_item_t  in_data_reg;

    // Result stage
    logic               out_valid_reg, out_valid_next;
    bpp_pkg::out_item_t out_data_reg, out_data_next;

    // Player state
    logic [TIME_WIDTH-1:0] start_time_reg, start_time_next;
    bpp_pkg::mode_t        stored_mode_reg, stored_mode_next;
    logic                  armed_reg, armed_next;

    logic                  advance;
    logic [NOW_W-1:0]      now_ext;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  elapsed_small;
    logic [bpp_pkg::LIMIT_W-1:0] elapsed_lo;

    logic [bpp_pkg::SINGLE_N-1:0]  single_le;
    logic [bpp_pkg::DOUBLE_N-1:0]  double_le;
    logic [bpp_pkg::WARNING_N-1:0] warning_le;
    logic single_lvl, double_lvl, warning_lvl;
    logic step_hit, step_lvl;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // Elapsed time, wrapping at TIME_WIDTH bits
    assign now_ext       = NOW_W'(in_data_reg.now_ms);
    assign now_t         = now_ext[TIME_WIDTH-1:0];
    assign elapsed       = now_t - start_time_reg;
    assign elapsed_lo    = elapsed[bpp_pkg::LIMIT_W-1:0];
    assign elapsed_small = (elapsed[TIME_WIDTH-1 -: HI_W] == '0);

    // Independent step compares, then pick the first step not yet exceeded
    always_comb begin
        for (int i = 0; i < bpp_pkg::SINGLE_N; i++) begin
            single_le[i] = elapsed_small && (elapsed_lo <= bpp_pkg::SINGLE_LIMIT[i]);
        end
        for (int i = 0; i < bpp_pkg::DOUBLE_N; i++) begin
            double_le[i] = elapsed_small && (elapsed_lo <= bpp_pkg::DOUBLE_LIMIT[i]);
        end
        for (int i = 0; i < bpp_pkg::WARNING_N; i++) begin
            warning_le[i] = elapsed_small && (elapsed_lo <= bpp_pkg::WARNING_LIMIT[i]);
        end

        single_lvl = 1'b0;
        for (int i = bpp_pkg::SINGLE_N - 1; i >= 0; i--) begin
            if (single_le[i]) single_lvl = bpp_pkg::SINGLE_LEVEL[i];
        end
        double_lvl = 1'b0;
        for (int i = bpp_pkg::DOUBLE_N - 1; i >= 0; i--) begin
            if (double_le[i]) double_lvl = bpp_pkg::DOUBLE_LEVEL[i];
        end
        warning_lvl = 1'b0;
        for (int i = bpp_pkg::WARNING_N - 1; i >= 0; i--) begin
            if (warning_le[i]) warning_lvl = bpp_pkg::WARNING_LEVEL[i];
        end
    end

    always_comb begin
        case (stored_mode_reg)
            bpp_pkg::MODE_SINGLE: begin
                step_hit = |single_le;
                step_lvl = single_lvl;
            end
            bpp_pkg::MODE_DOUBLE: begin
                step_hit = |double_le;
                step_lvl = double_lvl;
            end
            bpp_pkg::MODE_WARNING: begin
                step_hit = |warning_le;
                step_lvl = warning_lvl;
            end
            default: begin
                step_hit = 1'b0;
                step_lvl = 1'b0;
            end
        endcase
    end

    always_comb begin
        start_time_next  = start_time_reg;
        stored_mode_next = stored_mode_reg;
        armed_next       = armed_reg;
        out_data_next    = out_data_reg;

        if (advance) begin
            out_data_next = '0;
            case (in_data_reg.action)
                bpp_pkg::ACT_START: begin
                    stored_mode_next = in_data_reg.pattern_mode;
                    if (in_data_reg.pattern_mode != bpp_pkg::MODE_IDLE) begin
                        start_time_next  = now_t;
                        armed_next       = 1'b1;
                        out_data_next.ok = 1'b1;
                    end
                end
                bpp_pkg::ACT_PLAY: begin
                    if (armed_reg && stored_mode_reg != bpp_pkg::MODE_IDLE) begin
                        out_data_next.pin_write = 1'b1;
                        out_data_next.ok        = step_hit;
                        out_data_next.pin_high  = step_hit && step_lvl;
                        if (!step_hit) armed_next = 1'b0;
                    end
                end
                default: begin
                    out_data_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            start_time_reg  <= '0;
            stored_mode_reg <= bpp_pkg::MODE_IDLE;
            armed_reg       <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            start_time_reg  <= start_time_next;
            stored_mode_reg <= stored_mode_next;
            armed_reg       <= armed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) in_data_reg <= s_data;
        out_data_reg <= out_data_next;
    end

    // Input stage only back-pressures when it holds a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg)
        else $error("input stage stalled while empty");

    // A beeping start arms the player with the requested mode
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.action == bpp_pkg::ACT_START
            && in_data_reg.pattern_mode != bpp_pkg::MODE_IDLE
        |=> armed_reg && stored_mode_reg == $past(in_data_reg.pattern_mode))
        else $error("start did not arm the player");

    // Playing past the last step disarms
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && out_data_next.pin_write && !out_data_next.ok |=> !armed_reg)
        else $error("player still armed after pattern end");

    // Buzzer is never reported high without a pin write
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.pin_high || m_data.pin_write))
        else $error("pin_high set without pin_write");

    // A result loaded into the output stage means the input stage advanced
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result produced without an input transaction");

endmodule

`default_nettype wire
